[design/cet_pkg.sv]
// shared types and constants for the cell extreme tracker
package cet_pkg;

	// sample kinds
	localparam logic KIND_VOLT = 1'b0;
	localparam logic KIND_TEMP = 1'b1;

	// field widths
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned LOC_W   = 6;
	localparam int unsigned TOTAL_W = 28;

	// reports for a frame that received no sample
	localparam logic [VALUE_W-1:0] VOLT_EMPTY_LOW  = 16'hFFFF;
	localparam logic [VALUE_W-1:0] VOLT_EMPTY_HIGH = 16'h0000;
	localparam logic [VALUE_W-1:0] TEMP_EMPTY_LOW  = 16'h7FFF;
	localparam logic [VALUE_W-1:0] TEMP_EMPTY_HIGH = 16'h8000;

	// voltage total saturates at 4096 * 65535
	localparam logic [TOTAL_W:0] SUM_LIMIT = 29'd268431360;

	// one sample as it leaves the input register
	typedef struct packed {
		logic               kind;
		logic [LOC_W-1:0]   board;
		logic [LOC_W-1:0]   cell_num;
		logic [VALUE_W-1:0] value;
		logic               last;
	} sample_t;

	// control for one processing step
	typedef struct packed {
		logic fire;   // sample leaves the input register this cycle
		logic take;   // location in range, sample enters its frame
	} step_t;

	// extremes of a finished frame
	typedef struct packed {
		logic [VALUE_W-1:0] low_value;
		logic [LOC_W-1:0]   low_board;
		logic [LOC_W-1:0]   low_cell;
		logic [VALUE_W-1:0] high_value;
		logic [LOC_W-1:0]   high_board;
		logic [LOC_W-1:0]   high_cell;
	} report_t;

endpackage

[design/cet_extreme.sv]
// per-kind running minimum and maximum with their locations
module cet_extreme (
	input  logic            clk,
	input  logic            arst_n,
	input  cet_pkg::sample_t sample,
	input  cet_pkg::step_t   step,
	output cet_pkg::report_t report
);
	import cet_pkg::*;

	logic                 open_q      [2];
	logic [VALUE_W-1:0]   low_val_q   [2];
	logic [2*LOC_W-1:0]   low_place_q [2];
	logic [VALUE_W-1:0]   high_val_q  [2];
	logic [2*LOC_W-1:0]   high_place_q[2];

	logic                 cur_open;
	logic [VALUE_W-1:0]   cur_low, cur_high;
	logic [2*LOC_W-1:0]   cur_low_place, cur_high_place;
	logic [2*LOC_W-1:0]   place;
	logic [VALUE_W-1:0]   nxt_low, nxt_high;
	logic [2*LOC_W-1:0]   nxt_low_place, nxt_high_place;
	logic                 nxt_open;
	logic                 new_low, new_high;

	// strict less-than, sign bit flipped for temperatures
	function automatic logic below(input logic kind, input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		return {a[VALUE_W-1] ^ kind, a[VALUE_W-2:0]} < {b[VALUE_W-1] ^ kind, b[VALUE_W-2:0]};
	endfunction

	// read the frame of this sample's kind
	always_comb begin
		cur_open       = open_q[sample.kind];
		cur_low        = low_val_q[sample.kind];
		cur_high       = high_val_q[sample.kind];
		cur_low_place  = low_place_q[sample.kind];
		cur_high_place = high_place_q[sample.kind];
		place          = {sample.board, sample.cell_num};
	end

	// compare and update
	always_comb begin
		new_low        = !cur_open || below(sample.kind, sample.value, cur_low);
		new_high       = !cur_open || below(sample.kind, cur_high, sample.value);
		nxt_open       = cur_open || step.take;
		nxt_low        = cur_low;
		nxt_low_place  = cur_low_place;
		nxt_high       = cur_high;
		nxt_high_place = cur_high_place;
		if (step.take && new_low) begin
			nxt_low       = sample.value;
			nxt_low_place = place;
		end
		if (step.take && new_high) begin
			nxt_high       = sample.value;
			nxt_high_place = place;
		end
	end

	// report including the current sample
	always_comb begin
		if (nxt_open) begin
			report.low_value  = nxt_low;
			report.low_board  = nxt_low_place[2*LOC_W-1:LOC_W];
			report.low_cell   = nxt_low_place[LOC_W-1:0];
			report.high_value = nxt_high;
			report.high_board = nxt_high_place[2*LOC_W-1:LOC_W];
			report.high_cell  = nxt_high_place[LOC_W-1:0];
		end else begin
			report.low_value  = (sample.kind == KIND_TEMP) ? TEMP_EMPTY_LOW : VOLT_EMPTY_LOW;
			report.low_board  = '0;
			report.low_cell   = '0;
			report.high_value = (sample.kind == KIND_TEMP) ? TEMP_EMPTY_HIGH : VOLT_EMPTY_HIGH;
			report.high_board = '0;
			report.high_cell  = '0;
		end
	end

	// frame open flags, closed by the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q[0] <= 1'b0;
			open_q[1] <= 1'b0;
		end else if (step.fire) begin
			open_q[sample.kind] <= nxt_open && !sample.last;
		end
	end

	// extreme values and places
	always_ff @(posedge clk) begin
		if (step.fire && step.take) begin
			low_val_q[sample.kind]    <= nxt_low;
			low_place_q[sample.kind]  <= nxt_low_place;
			high_val_q[sample.kind]   <= nxt_high;
			high_place_q[sample.kind] <= nxt_high_place;
		end
	end

endmodule

[design/cell_extreme_tracker_core.sv]
// Cell extreme tracker: takes one cell sample per cycle and keeps, separately for voltage
// and temperature, the lowest and highest value with its board and cell (earliest sample
// wins a tie), plus a saturating voltage sum. A sample with tlast closes its kind's frame
// and yields one result via the input register and the result register. Throughput is
// one sample every cycle; the only loop is the compare-and-select on the held extremes.
// Samples whose board or cell lies beyond the configured counts are ignored except for
// their tlast. The input stalls only while a frame result waits on a stalled output.
module cell_extreme_tracker_core #(
	parameter int unsigned BOARD_COUNT        = 16,
	parameter int unsigned VOLT_CHANNELS      = 16,
	parameter int unsigned TEMP_CHANNEL_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// board_number[5:0], cell_number[11:6], sample_value[27:12], zero pad[31:28]
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// sample_kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// lowest_value[15:0], lowest_board[21:16], lowest_cell[27:22],
	// highest_value[43:28], highest_board[49:44], highest_cell[55:50],
	// voltage_total[83:56], zero pad[87:84]
	output logic [87:0] m_axis_tdata,
	// result_kind
	output logic        m_axis_tuser
);
	import cet_pkg::*;

	logic               s1_valid_s1;
	sample_t            sample_s1;
	step_t              step;
	report_t            report;
	logic               in_range;
	logic [LOC_W:0]     cell_limit;
	logic [TOTAL_W-1:0] sum_q;
	logic [TOTAL_W:0]   sum_add;
	logic [TOTAL_W-1:0] sum_nxt;
	logic               out_valid_q;
	logic               out_kind_q;
	report_t            out_report_q;
	logic [TOTAL_W-1:0] out_total_q;

	// input register advances unless it holds a last sample while a result is blocked at the output
	always_comb begin
		step.fire     = s1_valid_s1 && (!sample_s1.last || !out_valid_q || m_axis_tready);
		step.take     = in_range;
		s_axis_tready = !s1_valid_s1 || step.fire;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1.kind     <= s_axis_tuser;
			sample_s1.board    <= s_axis_tdata[5:0];
			sample_s1.cell_num <= s_axis_tdata[11:6];
			sample_s1.value    <= s_axis_tdata[27:12];
			sample_s1.last     <= s_axis_tlast;
		end
	end

	// location range check
	always_comb begin
		cell_limit = (sample_s1.kind == KIND_TEMP) ? (LOC_W+1)'(TEMP_CHANNEL_COUNT)
		                                           : (LOC_W+1)'(VOLT_CHANNELS);
		in_range   = ({1'b0, sample_s1.board} < (LOC_W+1)'(BOARD_COUNT)) &&
		             ({1'b0, sample_s1.cell_num} < cell_limit);
	end

	cet_extreme u_extreme (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_s1),
		.step   (step),
		.report (report)
	);

	// saturating voltage sum
	always_comb begin
		sum_add = {1'b0, sum_q} + {{(TOTAL_W+1-VALUE_W){1'b0}}, sample_s1.value};
		sum_nxt = sum_q;
		if (sample_s1.kind == KIND_VOLT && step.take) begin
			sum_nxt = (sum_add > SUM_LIMIT) ? SUM_LIMIT[TOTAL_W-1:0] : sum_add[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (step.fire && sample_s1.kind == KIND_VOLT) begin
			sum_q <= sample_s1.last ? '0 : sum_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.fire && sample_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && sample_s1.last) begin
			out_kind_q   <= sample_s1.kind;
			out_report_q <= report;
			out_total_q  <= (sample_s1.kind == KIND_VOLT) ? sum_nxt : '0;
		end
	end

	// output transfer
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {4'b0000, out_total_q,
	                        out_report_q.high_cell, out_report_q.high_board,
	                        out_report_q.high_value,
	                        out_report_q.low_cell, out_report_q.low_board,
	                        out_report_q.low_value};

`ifndef SYNTHESIS
	// the input register only holds while a result is blocked
	a_hold_reason: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !step.fire |-> out_valid_q && !m_axis_tready && sample_s1.last)
		else $error("input register held without a blocked result");

	// closing a voltage frame clears the sum
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && sample_s1.last && sample_s1.kind == KIND_VOLT |=> sum_q == '0)
		else $error("voltage sum not cleared after frame close");

	// the sum never passes its saturation bound
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, sum_q} <= SUM_LIMIT)
		else $error("voltage sum above saturation bound");

	// temperature results carry no voltage total
	a_temp_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_TEMP |-> out_total_q == '0)
		else $error("temperature result with nonzero voltage total");
`endif

endmodule

[verif/cell_extreme_tracker_core_test.sv]
// self-checking testbench for the cell extreme tracker core
`timescale 1ns / 100ps

module cell_extreme_tracker_core_test;
	import cet_pkg::*;

	localparam int unsigned BOARDS      = 16;
	localparam int unsigned VOLT_CELLS  = 16;
	localparam int unsigned TEMP_CELLS  = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 16;

	// one finished frame as it leaves the block
	typedef struct {
		logic               kind;
		logic [VALUE_W-1:0] low_value;
		logic [LOC_W-1:0]   low_board;
		logic [LOC_W-1:0]   low_cell;
		logic [VALUE_W-1:0] high_value;
		logic [LOC_W-1:0]   high_board;
		logic [LOC_W-1:0]   high_cell;
		logic [TOTAL_W-1:0] total;
	} frame_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// board_number[5:0], cell_number[11:6], sample_value[27:12], zero pad[31:28]
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	// sample_kind
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// lowest_value[15:0], lowest_board[21:16], lowest_cell[27:22], highest_value[43:28],
	// highest_board[49:44], highest_cell[55:50], voltage_total[83:56], zero pad[87:84]
	logic [87:0] m_axis_tdata;
	// result_kind
	logic        m_axis_tuser;

	// idling controls for sender and receiver, plus cycle and mismatch counts
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;

	// expected frame results, oldest first
	frame_report_t pending_reports[$];

	// running extremes per kind, index is the sample kind
	logic               frame_has_sample [2] = '{1'b0, 1'b0};
	logic [VALUE_W-1:0] min_value [2];
	logic [LOC_W-1:0]   min_board [2];
	logic [LOC_W-1:0]   min_cell  [2];
	logic [VALUE_W-1:0] max_value [2];
	logic [LOC_W-1:0]   max_board [2];
	logic [LOC_W-1:0]   max_cell  [2];
	logic [TOTAL_W:0]   volt_sum = '0;

	// random frame shaping per kind
	int unsigned frame_left  [2] = '{0, 0};
	int unsigned frame_style [2] = '{0, 0};

	cell_extreme_tracker_core #(
		.BOARD_COUNT        (BOARDS),
		.VOLT_CHANNELS      (VOLT_CELLS),
		.TEMP_CHANNEL_COUNT (TEMP_CELLS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// strict order in the encoding of the kind: voltage unsigned, temperature signed
	function automatic logic is_lower(input logic kind, input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		if (kind == KIND_VOLT)
			return a < b;
		return $signed(a) < $signed(b);
	endfunction

	// fold one accepted sample into the frame state, queue a result on frame end
	task automatic track_sample(input logic kind, input logic [LOC_W-1:0] board,
			input logic [LOC_W-1:0] cell_num, input logic [VALUE_W-1:0] value,
			input logic last);
		frame_report_t    rep;
		logic [TOTAL_W:0] next_sum;
		int unsigned      cell_limit;
		int               k;
		k = int'(kind);
		cell_limit = (kind == KIND_VOLT) ? VOLT_CELLS : TEMP_CELLS;
		if (board < BOARDS && cell_num < cell_limit) begin
			if (!frame_has_sample[k]) begin
				frame_has_sample[k] = 1'b1;
				min_value[k] = value;
				min_board[k] = board;
				min_cell[k]  = cell_num;
				max_value[k] = value;
				max_board[k] = board;
				max_cell[k]  = cell_num;
			end else begin
				if (is_lower(kind, value, min_value[k])) begin
					min_value[k] = value;
					min_board[k] = board;
					min_cell[k]  = cell_num;
				end
				if (is_lower(kind, max_value[k], value)) begin
					max_value[k] = value;
					max_board[k] = board;
					max_cell[k]  = cell_num;
				end
			end
			if (kind == KIND_VOLT) begin
				next_sum = volt_sum + value;
				volt_sum = (next_sum > SUM_LIMIT) ? SUM_LIMIT : next_sum;
			end
		end
		if (last) begin
			rep.kind = kind;
			if (frame_has_sample[k]) begin
				rep.low_value  = min_value[k];
				rep.low_board  = min_board[k];
				rep.low_cell   = min_cell[k];
				rep.high_value = max_value[k];
				rep.high_board = max_board[k];
				rep.high_cell  = max_cell[k];
			end else begin
				// empty frame reports the starting extremes
				rep.low_value  = (kind == KIND_VOLT) ? VOLT_EMPTY_LOW : TEMP_EMPTY_LOW;
				rep.high_value = (kind == KIND_VOLT) ? VOLT_EMPTY_HIGH : TEMP_EMPTY_HIGH;
				rep.low_board  = '0;
				rep.low_cell   = '0;
				rep.high_board = '0;
				rep.high_cell  = '0;
			end
			rep.total = (kind == KIND_VOLT) ? volt_sum[TOTAL_W-1:0] : '0;
			pending_reports.push_back(rep);
			frame_has_sample[k] = 1'b0;
			if (kind == KIND_VOLT)
				volt_sum = '0;
		end
	endtask

	// offer one sample, wait for its transfer, then predict
	task automatic send_sample(input logic kind, input logic [LOC_W-1:0] board,
			input logic [LOC_W-1:0] cell_num, input logic [VALUE_W-1:0] value,
			input logic last);
		int unsigned gap;
		logic        ready_seen;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, value, cell_num, board};
		s_axis_tlast  <= last;
		s_axis_tuser  <= kind;
		do begin
			@(negedge clk);
			ready_seen = s_axis_tready;
			@(posedge clk);
		end while (!ready_seen);
		track_sample(kind, board, cell_num, value, last);
	endtask

	// sender goes quiet until every expected result has come out
	task automatic pause_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			note_failure($sformatf("%s expected %0h actual %0h", name, want, got));
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	initial begin : result_receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (hold_request > 0) begin
				m_axis_tready <= 1'b0;
				hold_left = hold_request - 1;
				hold_request = 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checker: a transfer is seen on the falling edge ahead of the edge that takes it
	initial begin : result_checker
		frame_report_t got;
		frame_report_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.kind       = m_axis_tuser;
				got.low_value  = m_axis_tdata[15:0];
				got.low_board  = m_axis_tdata[21:16];
				got.low_cell   = m_axis_tdata[27:22];
				got.high_value = m_axis_tdata[43:28];
				got.high_board = m_axis_tdata[49:44];
				got.high_cell  = m_axis_tdata[55:50];
				got.total      = m_axis_tdata[83:56];
				if (pending_reports.size() == 0) begin
					note_failure($sformatf("unexpected result, kind %0d low %0h high %0h",
						got.kind, got.low_value, got.high_value));
				end else begin
					want = pending_reports.pop_front();
					check_field("result_kind", 32'(want.kind), 32'(got.kind));
					check_field("lowest_value", 32'(want.low_value), 32'(got.low_value));
					check_field("lowest_board", 32'(want.low_board), 32'(got.low_board));
					check_field("lowest_cell", 32'(want.low_cell), 32'(got.low_cell));
					check_field("highest_value", 32'(want.high_value), 32'(got.high_value));
					check_field("highest_board", 32'(want.high_board), 32'(got.high_board));
					check_field("highest_cell", 32'(want.high_cell), 32'(got.high_cell));
					check_field("voltage_total", 32'(want.total), 32'(got.total));
					check_field("zero pad", 32'd0, 32'(m_axis_tdata[87:84]));
				end
			end
		end
	end

	// empty frames, ties, sign handling, out-of-range places, single samples
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_sample(KIND_VOLT, 6'd16, 6'd0, 16'h1234, 1'b1);
		send_sample(KIND_TEMP, 6'd0, 6'd63, 16'h0000, 1'b1);
		send_sample(KIND_VOLT, 6'd15, 6'd15, 16'hFFFF, 1'b0);
		send_sample(KIND_TEMP, 6'd2, 6'd3, 16'h7FFF, 1'b0);
		send_sample(KIND_VOLT, 6'd0, 6'd0, 16'h0000, 1'b0);
		send_sample(KIND_TEMP, 6'd4, 6'd5, 16'h8000, 1'b0);
		send_sample(KIND_VOLT, 6'd1, 6'd2, 16'h0000, 1'b0);
		send_sample(KIND_TEMP, 6'd6, 6'd7, 16'hFFFF, 1'b0);
		send_sample(KIND_VOLT, 6'd3, 6'd4, 16'hFFFF, 1'b0);
		send_sample(KIND_TEMP, 6'd8, 6'd9, 16'h8000, 1'b0);
		send_sample(KIND_TEMP, 6'd10, 6'd11, 16'h7FFF, 1'b0);
		// the first two closing samples lie outside the fitted boards and cells
		send_sample(KIND_VOLT, 6'd63, 6'd63, 16'h0001, 1'b1);
		send_sample(KIND_TEMP, 6'd0, 6'd16, 16'h0000, 1'b1);
		send_sample(KIND_VOLT, 6'd7, 6'd7, 16'h8000, 1'b1);
		send_sample(KIND_TEMP, 6'd15, 6'd0, 16'h0001, 1'b1);
		send_sample(KIND_VOLT, 6'd0, 6'd15, 16'h5555, 1'b0);
		send_sample(KIND_VOLT, 6'd15, 6'd0, 16'hAAAA, 1'b1);
		send_sample(KIND_TEMP, 6'd42, 6'd21, 16'h2A2A, 1'b0);
		send_sample(KIND_TEMP, 6'd0, 6'd0, 16'hFFFE, 1'b1);
		pause_until_drained();
	endtask

	// interleaved frames of both kinds with random content and some noise
	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic               kind;
		logic               last;
		logic [LOC_W-1:0]   board;
		logic [LOC_W-1:0]   cell_num;
		logic [VALUE_W-1:0] value;
		int unsigned        cell_limit;
		int                 k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			kind = 1'($urandom_range(1));
			k = int'(kind);
			if (frame_left[k] == 0) begin
				frame_left[k]  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
				frame_style[k] = $urandom_range(3);
			end
			frame_left[k]--;
			last = (frame_left[k] == 0);
			cell_limit = (kind == KIND_VOLT) ? VOLT_CELLS : TEMP_CELLS;
			if ($urandom_range(99) < 12) begin
				board    = 6'($urandom_range(63));
				cell_num = 6'($urandom_range(63));
			end else begin
				board    = 6'($urandom_range(BOARDS - 1));
				cell_num = 6'($urandom_range(cell_limit - 1));
			end
			case (frame_style[k])
				0: value = 16'($urandom);
				1: begin
					case ($urandom_range(3))
						0: value = 16'h0000;
						1: value = 16'hFFFF;
						2: value = 16'h7FFF;
						default: value = 16'h8000;
					endcase
				end
				// narrow spread so ties are common
				2: value = 16'h1230 + 16'($urandom_range(3));
				default: begin
					if (kind == KIND_VOLT)
						value = 16'd3000 + 16'($urandom_range(1200));
					else
						value = 16'($urandom_range(120)) - 16'd40;
				end
			endcase
			send_sample(kind, board, cell_num, value, last);
		end
	endtask

	// receiver holds off for a long stretch while samples keep closing frames
	task automatic test_output_backpressure();
		logic kind;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 300;
		repeat (40) begin
			kind = 1'($urandom_range(1));
			send_sample(kind, 6'($urandom_range(BOARDS - 1)), 6'($urandom_range(15)),
				16'($urandom), 1'b1);
		end
		pause_until_drained();
	endtask

	// test sequence
	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(440, 0, 0);
		pause_until_drained();
		test_random_traffic(440, 53, 0);
		pause_until_drained();
		test_output_backpressure();
		test_random_traffic(440, 0, 53);
		pause_until_drained();
		test_random_traffic(440, 38, 38);
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
